// File: rtl/six_bit_ascii_frame_decoder_macros.svh
// Assertion macros used by the port-level checker of the frame decoder.
`ifndef SIX_BIT_ASCII_FRAME_DECODER_MACROS_SVH
`define SIX_BIT_ASCII_FRAME_DECODER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define FSD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define FSD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fsd_pkg.sv
// Package with the types and constants of the six-bit frame decoder.
`timescale 1ns / 1ps

package fsd_pkg;

	// Framing characters and the digit range.
	localparam logic [7:0] CH_STX     = 8'h02;
	localparam logic [7:0] CH_ETX     = 8'h03;
	localparam logic [7:0] DIGIT_BASE = 8'd48;
	localparam logic [7:0] DIGIT_LAST = 8'd111;

	// Reset value of the frame length limit.
	localparam logic [15:0] MAX_FRAME_BYTES_RST = 16'd264;

	// Frame status codes carried on the end result.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_MALFORMED = 2'd2
	} status_t;

	// One result item.
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        frame_end;
		status_t     frame_status;
		logic [15:0] frame_bytes;
	} result_t;

endpackage

// File: rtl/six_bit_ascii_frame_decoder.sv
// Top level of the six-bit printable frame decoder.
// The decoder takes one received character per cycle: STX opens a frame,
// each character from 48 to 111 adds a six-bit digit, and every completed
// byte within the frame length limit appears as a data result, while ETX
// closes the frame with an end result that carries the status and the byte
// count. A character is held in an input register, decoded against the
// frame state and written into a two-entry output buffer, so a result is
// offered from the output buffer register once its character has passed
// the input register. One transfer per cycle is sustained as long as
// results are taken; when both output buffer entries are full the input
// side stalls until the downstream side takes a result.
`timescale 1ns / 1ps

module six_bit_ascii_frame_decoder
	import fsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic [1:0]  frame_status,
	output logic [15:0] frame_bytes
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       room;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    out_data;

	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// Input register: holds the character until the decoder can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= rx_char;
		end
	end

	// Decoder with frame state.
	fsd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.char_s1     (char_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result buffer toward the output channel.
	fsd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && res_valid),
		.push_data (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign out_byte     = out_data.out_byte;
	assign frame_end    = out_data.frame_end;
	assign frame_status = out_data.frame_status;
	assign frame_bytes  = out_data.frame_bytes;

endmodule

// File: rtl/fsd_core.sv
// Frame state and per-character decode of the six-bit frame decoder.
`timescale 1ns / 1ps

module fsd_core
	import fsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        step,
	input  logic [7:0]  char_s1,
	output logic        res_valid,
	output result_t     res
);

	logic [15:0] max_frame_bytes_q;
	logic        in_frame_q, in_frame_n;
	logic [1:0]  phase_q, phase_n;
	logic [5:0]  carry_q, carry_n;
	logic [15:0] count_q, count_n;
	logic        overflow_q, overflow_n;
	logic        malformed_q, malformed_n;
	logic [7:0]  diff;
	logic [5:0]  digit;
	logic        emit;
	logic [7:0]  byte_c;
	logic        malformed_end;

	assign diff  = char_s1 - DIGIT_BASE;
	assign digit = diff[5:0];

	// Limit register; the user must write it only while the block is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= MAX_FRAME_BYTES_RST;
		end else if (cfg_wr_en) begin
			max_frame_bytes_q <= cfg_wr_data;
		end
	end

	// Next frame state and the result of the current character.
	always_comb begin
		in_frame_n    = in_frame_q;
		phase_n       = phase_q;
		carry_n       = carry_q;
		count_n       = count_q;
		overflow_n    = overflow_q;
		malformed_n   = malformed_q;
		emit          = 1'b0;
		byte_c        = '0;
		res_valid     = 1'b0;
		res           = '0;
		malformed_end = malformed_q || (phase_q == 2'd1);
		if (char_s1 == CH_STX) begin
			in_frame_n  = 1'b1;
			phase_n     = '0;
			carry_n     = '0;
			count_n     = '0;
			overflow_n  = 1'b0;
			malformed_n = 1'b0;
		end else if (in_frame_q) begin
			if (char_s1 == CH_ETX) begin
				res_valid       = 1'b1;
				res.frame_end   = 1'b1;
				res.frame_bytes = count_q;
				if (overflow_q) begin
					res.frame_status = STATUS_OVERFLOW;
				end else if (malformed_end) begin
					res.frame_status = STATUS_MALFORMED;
				end else begin
					res.frame_status = STATUS_OK;
				end
				in_frame_n  = 1'b0;
				phase_n     = '0;
				carry_n     = '0;
				count_n     = '0;
				overflow_n  = 1'b0;
				malformed_n = 1'b0;
			end else if (!(char_s1 inside {[DIGIT_BASE:DIGIT_LAST]})) begin
				malformed_n = 1'b1;
			end else begin
				case (phase_q)
					2'd0: begin
						carry_n = digit;
						phase_n = 2'd1;
					end
					2'd1: begin
						byte_c  = {digit[1:0], carry_q};
						carry_n = {2'b00, digit[5:2]};
						phase_n = 2'd2;
						emit    = 1'b1;
					end
					2'd2: begin
						byte_c  = {digit[3:0], carry_q[3:0]};
						carry_n = {4'b0000, digit[5:4]};
						phase_n = 2'd3;
						emit    = 1'b1;
					end
					default: begin
						byte_c  = {digit, carry_q[1:0]};
						carry_n = '0;
						phase_n = 2'd0;
						emit    = 1'b1;
					end
				endcase
			end
		end
		// A completed byte is delivered unless the frame is already full.
		if (emit) begin
			if (count_q >= max_frame_bytes_q) begin
				overflow_n = 1'b1;
			end else begin
				count_n      = count_q + 16'd1;
				res_valid    = 1'b1;
				res.out_byte = byte_c;
			end
		end
	end

	// Frame state registers advance once per processed character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			phase_q     <= '0;
			carry_q     <= '0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			malformed_q <= 1'b0;
		end else if (step) begin
			in_frame_q  <= in_frame_n;
			phase_q     <= phase_n;
			carry_q     <= carry_n;
			count_q     <= count_n;
			overflow_q  <= overflow_n;
			malformed_q <= malformed_n;
		end
	end

endmodule

// File: rtl/fsd_out_buf.sv
// Two-entry result register with skid stage for the six-bit frame decoder.
`timescale 1ns / 1ps

module fsd_out_buf
	import fsd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign room      = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign pop       = main_valid_q && out_ready;

	// Valid flags of the result and skid entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// Payload moves into the free entry; the skid entry refills the result entry.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

// File: rtl/fsd_checker.sv
// Port-level checker of the six-bit frame decoder and its bind.
`timescale 1ns / 1ps
`include "six_bit_ascii_frame_decoder_macros.svh"

module fsd_checker
	import fsd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [15:0] cfg_wr_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_char,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        frame_end,
	input logic [1:0]  frame_status,
	input logic [15:0] frame_bytes
);

	// A stalled result keeps its valid and its payload.
	`FSD_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end) && $stable(frame_status) && $stable(frame_bytes), "stalled result changed")

	// A data result carries no status and no count.
	`FSD_ASSERT(a_data_clean, clk, arst_n, out_valid && !frame_end |-> frame_status == STATUS_OK && frame_bytes == 16'd0, "data result with end fields set")

	// An end result carries a zero byte and a defined status.
	`FSD_ASSERT(a_end_clean, clk, arst_n, out_valid && frame_end |-> out_byte == 8'd0 && frame_status != 2'd3, "end result with bad byte or status")

	// No result is offered while reset is applied; the flag may still be unknown at the first edge.
	`FSD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> out_valid !== 1'b1, "result offered during reset")

endmodule

bind six_bit_ascii_frame_decoder fsd_checker u_fsd_checker (.*);

// File: verif/fsd_result_checker.sv
// Result checker for the six-bit frame decoder: predicts every result and compares it.
`timescale 1ns / 1ps

module fsd_result_checker
	import fsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         rx_char,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         out_byte,
	input  logic               frame_end,
	input  logic [1:0]         frame_status,
	input  logic [15:0]        frame_bytes,
	output int unsigned        mismatch_count,
	output int unsigned        results_awaited
);

	// Shadow copy of the decoder's frame state and its length limit.
	logic        in_frame      = 1'b0;
	logic [1:0]  digit_phase   = 2'd0;
	logic [5:0]  carry_bits    = 6'd0;
	logic [15:0] byte_count    = 16'd0;
	logic        overflow_seen = 1'b0;
	logic        malformed_seen = 1'b0;
	logic [15:0] frame_limit   = MAX_FRAME_BYTES_RST;

	// Decoded bytes and frame ends that the decoder still owes, oldest first.
	result_t     awaited_results[$];
	int unsigned n_mismatch = 0;
	int unsigned n_awaited  = 0;

	assign mismatch_count  = n_mismatch;
	assign results_awaited = n_awaited;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		n_mismatch++;
	endtask

	task automatic clear_frame();
		digit_phase    = 2'd0;
		carry_bits     = 6'd0;
		byte_count     = 16'd0;
		overflow_seen  = 1'b0;
		malformed_seen = 1'b0;
	endtask

	// Work out what one received character produces, if anything.
	task automatic decode_char(input logic [7:0] c, output bit produced, output result_t res);
		logic [5:0] digit;
		logic [7:0] data;
		bit         have_byte;
		produced  = 1'b0;
		have_byte = 1'b0;
		res       = '0;
		data      = 8'd0;
		if (c == CH_STX) begin
			// Start of frame, also when a frame is already open.
			in_frame = 1'b1;
			clear_frame();
		end else if (in_frame) begin
			if (c == CH_ETX) begin
				// A lone digit in the last group cannot form a byte.
				if (digit_phase == 2'd1)
					malformed_seen = 1'b1;
				res.frame_end = 1'b1;
				if (overflow_seen)
					res.frame_status = STATUS_OVERFLOW;
				else if (malformed_seen)
					res.frame_status = STATUS_MALFORMED;
				else
					res.frame_status = STATUS_OK;
				res.frame_bytes = byte_count;
				produced = 1'b1;
				in_frame = 1'b0;
				clear_frame();
			end else if (c < DIGIT_BASE || c > DIGIT_LAST) begin
				malformed_seen = 1'b1;
			end else begin
				digit = 6'(c - DIGIT_BASE);
				case (digit_phase)
					2'd0: begin
						carry_bits  = digit;
						digit_phase = 2'd1;
					end
					2'd1: begin
						data        = {digit[1:0], carry_bits};
						carry_bits  = {2'b00, digit[5:2]};
						digit_phase = 2'd2;
						have_byte   = 1'b1;
					end
					2'd2: begin
						data        = {digit[3:0], carry_bits[3:0]};
						carry_bits  = {4'b0000, digit[5:4]};
						digit_phase = 2'd3;
						have_byte   = 1'b1;
					end
					default: begin
						data        = {digit, carry_bits[1:0]};
						carry_bits  = 6'd0;
						digit_phase = 2'd0;
						have_byte   = 1'b1;
					end
				endcase
				// Bytes past the limit are dropped and flag the frame.
				if (have_byte) begin
					if (byte_count >= frame_limit) begin
						overflow_seen = 1'b1;
					end else begin
						byte_count   = byte_count + 16'd1;
						res.out_byte = data;
						produced     = 1'b1;
					end
				end
			end
		end
	endtask

	// Compare each result transfer, then track writes and predict on input transfers.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t res;
		bit      produced;
		if (!arst_n) begin
			in_frame    = 1'b0;
			frame_limit = MAX_FRAME_BYTES_RST;
			clear_frame();
			awaited_results.delete();
			n_awaited <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %0h end %0b status %0d count %0d",
						out_byte, frame_end, frame_status, frame_bytes));
				end else begin
					want = awaited_results.pop_front();
					if (out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte expected %0h, got %0h",
							want.out_byte, out_byte));
					if (frame_end !== want.frame_end)
						report_mismatch($sformatf("frame_end expected %0b, got %0b",
							want.frame_end, frame_end));
					if (frame_status !== 2'(want.frame_status))
						report_mismatch($sformatf("frame_status expected %0d, got %0d",
							want.frame_status, frame_status));
					if (frame_bytes !== want.frame_bytes)
						report_mismatch($sformatf("frame_bytes expected %0d, got %0d",
							want.frame_bytes, frame_bytes));
				end
			end
			if (cfg_wr_en)
				frame_limit = cfg_wr_data;
			if (in_valid && in_ready) begin
				decode_char(rx_char, produced, res);
				if (produced)
					awaited_results.push_back(res);
			end
			n_awaited <= awaited_results.size();
		end
	end

endmodule

// File: verif/tb_six_bit_ascii_frame_decoder.sv
// Testbench top for the six-bit frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_six_bit_ascii_frame_decoder;
	import fsd_pkg::*;

	localparam int PHASE_CHARS  = 107;
	localparam int DRAIN_CYCLES = 6;
	localparam int TIMEOUT_NS   = 10_000_000;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_char     = 8'd0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_end;
	logic [1:0]  frame_status;
	logic [15:0] frame_bytes;

	int unsigned mismatch_count;
	int unsigned results_awaited;
	bit          steady      = 1'b0;
	int unsigned ready_hold  = 0;

	// Character sequences for the directed part.
	logic [7:0] directed_chars[] = '{
		CH_ETX, 8'h41,
		CH_STX, 8'd48, 8'd111, 8'd111, 8'd48, CH_ETX,
		CH_STX, 8'd48, 8'd47, 8'd112, 8'hff, 8'd60, CH_ETX,
		CH_STX, 8'd77, CH_STX, 8'd65, 8'd90, CH_ETX,
		CH_STX, 8'd100, CH_ETX
	};

	// Limits walked through after the directed part, extremes included.
	logic [15:0] phase_limits[] = '{
		16'd1, 16'd0, 16'hffff, 16'd3, 16'd7, MAX_FRAME_BYTES_RST
	};

	six_bit_ascii_frame_decoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_char     (rx_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.frame_end   (frame_end),
		.frame_status(frame_status),
		.frame_bytes (frame_bytes)
	);

	fsd_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_char        (rx_char),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.frame_end      (frame_end),
		.frame_status   (frame_status),
		.frame_bytes    (frame_bytes),
		.mismatch_count (mismatch_count),
		.results_awaited(results_awaited)
	);

	always #4 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Downstream side stalls at random, except in steady stretches.
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (steady || $urandom_range(0, 2) != 0) begin
			out_ready  <= 1'b1;
			ready_hold <= $urandom_range(0, 8);
		end else begin
			out_ready  <= 1'b0;
			ready_hold <= 1 + gap_cycles();
		end
	end

	// One character transfer; returns at the edge where it is taken.
	task automatic send_char(input logic [7:0] c);
		int unsigned g;
		g = steady ? 0 : gap_cycles();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_char  <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	// Wait until every predicted result is out and the pipeline has emptied.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_awaited != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] limit);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= limit;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// One frame with random digits, some noise, and now and then no ETX.
	task automatic random_frame(inout int sent);
		int unsigned n_digits;
		int unsigned n_junk;
		bit          closed;
		n_digits = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 14) : $urandom_range(15, 48);
		send_char(CH_STX);
		sent++;
		repeat (n_digits) begin
			if ($urandom_range(0, 99) < 4)
				send_char(8'($urandom_range(0, 255)));
			else
				send_char(8'($urandom_range(DIGIT_BASE, DIGIT_LAST)));
			sent++;
		end
		closed = ($urandom_range(0, 99) < 92);
		if (closed) begin
			send_char(CH_ETX);
			sent++;
			// Characters between frames are ignored by the decoder.
			if ($urandom_range(0, 9) == 0) begin
				n_junk = $urandom_range(1, 2);
				repeat (n_junk)
					send_char(($urandom_range(0, 1) != 0) ? CH_ETX : 8'($urandom_range(48, 255)));
			end
		end
	endtask

	task automatic random_phase(input int count);
		int sent;
		sent = 0;
		while (sent < count)
			random_frame(sent);
	endtask

	// Reset, directed characters, then random frames under each limit.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_chars[i])
			send_char(directed_chars[i]);
		random_phase(PHASE_CHARS);
		foreach (phase_limits[p]) begin
			write_limit(phase_limits[p]);
			steady <= (p == 2);
			random_phase(PHASE_CHARS);
		end
		wait_idle();
		if (mismatch_count == 0 && results_awaited == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
